/* src/sprf_pkg.sv */
// semiprime range finder: control word layout, opcodes, branch conditions
// and the microprogram rom
// no dependencies
package sprf_pkg;

	localparam int FIELD_BITS = 16;
	localparam int PC_BITS    = 4;

	typedef logic [PC_BITS-1:0] pc_t;
	typedef logic [3:0]         op_t;
	typedef logic [3:0]         cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// datapath operations
	localparam op_t OP_NOP       = 4'd0;
	localparam op_t OP_LOAD      = 4'd1;  // wait for a range transfer
	localparam op_t OP_TEST_INIT = 4'd2;  // cofactor <= candidate, divisor <= 2
	localparam op_t OP_DIV_START = 4'd3;
	localparam op_t OP_DIV_WAIT  = 4'd4;
	localparam op_t OP_DIV_TAKE  = 4'd5;  // cofactor <= quotient, count factor
	localparam op_t OP_INC_D     = 4'd6;
	localparam op_t OP_EMIT_PEND = 4'd7;  // release held semiprime, hold new one
	localparam op_t OP_INC_N     = 4'd8;
	localparam op_t OP_EMIT_LAST = 4'd9;
	localparam op_t OP_EMIT_ERR  = 4'd10;

	// branch conditions
	localparam cond_t C_NEVER     = 4'd0;
	localparam cond_t C_ALWAYS    = 4'd1;
	localparam cond_t C_RANGE_BAD = 4'd2;
	localparam cond_t C_N_LT4     = 4'd3;
	localparam cond_t C_DSQ_GT_C  = 4'd4;
	localparam cond_t C_REM_NZ    = 4'd5;
	localparam cond_t C_FACT_EQ2  = 4'd6;
	localparam cond_t C_NOT_SEMI  = 4'd7;
	localparam cond_t C_N_EQ_HI   = 4'd8;

	// program addresses
	localparam pc_t A_IDLE      = 4'd0;
	localparam pc_t A_CHECK     = 4'd1;
	localparam pc_t A_TEST      = 4'd2;
	localparam pc_t A_LOOP      = 4'd3;
	localparam pc_t A_DIV       = 4'd4;
	localparam pc_t A_DIV_WAIT  = 4'd5;
	localparam pc_t A_REM_TEST  = 4'd6;
	localparam pc_t A_TAKE      = 4'd7;
	localparam pc_t A_RETRY     = 4'd8;
	localparam pc_t A_INC_D     = 4'd9;
	localparam pc_t A_VERDICT   = 4'd10;
	localparam pc_t A_FOUND     = 4'd11;
	localparam pc_t A_NEXT_N    = 4'd12;
	localparam pc_t A_INC_N     = 4'd13;
	localparam pc_t A_END       = 4'd14;
	localparam pc_t A_ERR       = 4'd15;

	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE};
		unique case (pc)
			A_IDLE:     w = '{op: OP_LOAD,      cond: C_NEVER,     target: A_IDLE};
			A_CHECK:    w = '{op: OP_NOP,       cond: C_RANGE_BAD, target: A_ERR};
			A_TEST:     w = '{op: OP_TEST_INIT, cond: C_N_LT4,     target: A_NEXT_N};
			A_LOOP:     w = '{op: OP_NOP,       cond: C_DSQ_GT_C,  target: A_VERDICT};
			A_DIV:      w = '{op: OP_DIV_START, cond: C_NEVER,     target: A_IDLE};
			A_DIV_WAIT: w = '{op: OP_DIV_WAIT,  cond: C_NEVER,     target: A_IDLE};
			A_REM_TEST: w = '{op: OP_NOP,       cond: C_REM_NZ,    target: A_INC_D};
			A_TAKE:     w = '{op: OP_DIV_TAKE,  cond: C_FACT_EQ2,  target: A_NEXT_N};
			A_RETRY:    w = '{op: OP_NOP,       cond: C_ALWAYS,    target: A_DIV};
			A_INC_D:    w = '{op: OP_INC_D,     cond: C_ALWAYS,    target: A_LOOP};
			A_VERDICT:  w = '{op: OP_NOP,       cond: C_NOT_SEMI,  target: A_NEXT_N};
			A_FOUND:    w = '{op: OP_EMIT_PEND, cond: C_NEVER,     target: A_IDLE};
			A_NEXT_N:   w = '{op: OP_NOP,       cond: C_N_EQ_HI,   target: A_END};
			A_INC_N:    w = '{op: OP_INC_N,     cond: C_ALWAYS,    target: A_TEST};
			A_END:      w = '{op: OP_EMIT_LAST, cond: C_ALWAYS,    target: A_IDLE};
			A_ERR:      w = '{op: OP_EMIT_ERR,  cond: C_ALWAYS,    target: A_IDLE};
			default:    w = '{op: OP_NOP,       cond: C_ALWAYS,    target: A_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* src/semiprime_range_finder.sv */
// semiprime range finder top level: microcoded sequencer, trial-division
// datapath with a single restoring divider, output register
// depends on sprf_pkg
// one range at a time, of up to MAX_SPAN numbers; trial division runs in the
// one-bit-per-cycle divider, once per divisor up to the square root of the
// remaining cofactor; a rejected range gives only an error result
// results are released one behind the scan so the final one can carry tlast
// reset returns the sequencer to idle and drops any held or pending result
module semiprime_range_finder
	import sprf_pkg::*;
#(
	parameter int VALUE_BITS = 16,
	parameter int MAX_SPAN   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // range_low, range_high
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // semiprime_value
	output logic [1:0]  m_axis_tuser,   // found, range_error
	output logic        m_axis_tlast    // last_of_run
);

	localparam int NW    = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
	localparam int CNT_W = $clog2(NW + 1);

	// sequencer
	pc_t    pc_q;
	uword_t uw;
	logic   op_done;
	logic   cond_true;

	// datapath
	logic [NW-1:0]    candidate_q;
	logic [NW-1:0]    upper_bound_q;
	logic [NW-1:0]    cofactor_q;
	logic [NW-1:0]    divisor_q;
	logic [1:0]       factors_q;
	logic [NW-1:0]    pend_q;
	logic             pend_v_q;

	// divider
	logic [NW-1:0]    div_rem_q;
	logic [NW-1:0]    div_quo_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             div_busy_q;
	logic [NW:0]      div_shift;
	logic [NW:0]      div_diff;
	logic             div_ge;

	// output register
	logic             out_valid_q;
	logic [NW-1:0]    out_value_q;
	logic             out_found_q;
	logic             out_last_q;
	logic             out_err_q;
	logic             out_free;

	logic [2*NW-1:0]  div_sq;
	logic [NW-1:0]    span_diff;
	logic             range_bad;
	logic [2:0]       factor_total;

	assign uw       = ucode_rom(pc_q);
	assign out_free = !out_valid_q || m_axis_tready;

	assign div_sq       = divisor_q * divisor_q;
	assign span_diff    = upper_bound_q - candidate_q;
	assign range_bad    = (candidate_q == '0) || (candidate_q > upper_bound_q) ||
		(32'(span_diff) >= 32'(MAX_SPAN));
	assign factor_total = {1'b0, factors_q} + {2'b00, (cofactor_q > NW'(1))};

	always_comb begin
		case (uw.op)
			OP_LOAD:      op_done = s_axis_tvalid;
			OP_DIV_WAIT:  op_done = !div_busy_q;
			OP_EMIT_PEND: op_done = !pend_v_q || out_free;
			OP_EMIT_LAST: op_done = out_free;
			OP_EMIT_ERR:  op_done = out_free;
			default:      op_done = 1'b1;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			C_NEVER:     cond_true = 1'b0;
			C_ALWAYS:    cond_true = 1'b1;
			C_RANGE_BAD: cond_true = range_bad;
			C_N_LT4:     cond_true = candidate_q < NW'(4);
			C_DSQ_GT_C:  cond_true = div_sq > {{NW{1'b0}}, cofactor_q};
			C_REM_NZ:    cond_true = div_rem_q != '0;
			C_FACT_EQ2:  cond_true = factors_q == 2'd2;
			C_NOT_SEMI:  cond_true = factor_total != 3'd2;
			C_N_EQ_HI:   cond_true = candidate_q == upper_bound_q;
			default:     cond_true = 1'b0;
		endcase
	end

	assign s_axis_tready = (uw.op == OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else if (op_done) begin
			pc_q <= cond_true ? uw.target : pc_q + pc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (op_done) begin
			case (uw.op)
				OP_LOAD:      pend_v_q <= 1'b0;
				OP_EMIT_PEND: pend_v_q <= 1'b1;
				default:      pend_v_q <= pend_v_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_done) begin
			case (uw.op)
				OP_LOAD: begin
					candidate_q   <= s_axis_tdata[NW-1:0];
					upper_bound_q <= s_axis_tdata[16 +: NW];
				end
				OP_TEST_INIT: begin
					cofactor_q <= candidate_q;
					divisor_q  <= NW'(2);
					factors_q  <= 2'd0;
				end
				OP_DIV_TAKE: begin
					cofactor_q <= div_quo_q;
					factors_q  <= factors_q + 2'd1;
				end
				OP_INC_D:     divisor_q   <= divisor_q + NW'(1);
				OP_INC_N:     candidate_q <= candidate_q + NW'(1);
				OP_EMIT_PEND: pend_q      <= candidate_q;
				default: ;
			endcase
		end
	end

	// restoring division, one quotient bit per cycle
	assign div_shift = {div_rem_q, div_quo_q[NW-1]};
	assign div_diff  = div_shift - {1'b0, divisor_q};
	assign div_ge    = div_shift >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (uw.op == OP_DIV_START) begin
			div_busy_q <= 1'b1;
		end else if (div_busy_q && div_cnt_q == CNT_W'(1)) begin
			div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_DIV_START) begin
			div_rem_q <= '0;
			div_quo_q <= cofactor_q;
			div_cnt_q <= CNT_W'(NW);
		end else if (div_busy_q) begin
			div_rem_q <= div_ge ? div_diff[NW-1:0] : div_shift[NW-1:0];
			div_quo_q <= {div_quo_q[NW-2:0], div_ge};
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
	end

	// output register; a held semiprime is released once the next one shows up, or with tlast at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_done && ((uw.op == OP_EMIT_PEND && pend_v_q) ||
			uw.op == OP_EMIT_LAST || uw.op == OP_EMIT_ERR)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_done) begin
			case (uw.op)
				OP_EMIT_PEND: begin
					if (pend_v_q) begin
						out_value_q <= pend_q;
						out_found_q <= 1'b1;
						out_last_q  <= 1'b0;
						out_err_q   <= 1'b0;
					end
				end
				OP_EMIT_LAST: begin
					out_value_q <= pend_v_q ? pend_q : '0;
					out_found_q <= pend_v_q;
					out_last_q  <= 1'b1;
					out_err_q   <= 1'b0;
				end
				OP_EMIT_ERR: begin
					out_value_q <= '0;
					out_found_q <= 1'b0;
					out_last_q  <= 1'b1;
					out_err_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = FIELD_BITS'(out_value_q);
	assign m_axis_tuser  = {out_err_q, out_found_q};
	assign m_axis_tlast  = out_last_q;

endmodule
